FILE: rtl/rrcm_pkg.sv
package rrcm_pkg;

    // Field and register widths
    localparam int PIX_BITS    = 12;
    localparam int SIZE_BITS   = 12;
    localparam int SCREEN_BITS = 13;
    localparam int STYLE_BITS  = 2;
    localparam int ACT_BITS    = 2;
    localparam int INDEX_BITS  = 3;

    // Corner radius tops out at 4095 / 10, so the root and its square stay narrow
    localparam int ROOT_BITS  = 9;
    localparam int SQ_BITS    = 2 * ROOT_BITS;
    localparam int SQRT_STEPS = ROOT_BITS;

    // m / 10 as (m * 6554) >> 16, exact for every 12-bit m
    localparam int                    DIV10_MUL_BITS = 13;
    localparam logic [DIV10_MUL_BITS-1:0] DIV10_MUL  = 13'd6554;
    localparam int                    DIV10_SHIFT    = 16;

    // Side limits for the radius rule
    localparam logic [SIZE_BITS-1:0] MIN_SCALED_SIDE = 12'd5;
    localparam logic [SIZE_BITS-1:0] MIN_ROUND_SIDE  = 12'd3;
    localparam logic [ROOT_BITS-1:0] SMALL_RADIUS    = 9'd1;
    localparam logic [ROOT_BITS-1:0] MIN_RADIUS      = 9'd2;

    localparam logic [SCREEN_BITS-1:0] SCREEN_RESET = 13'd4096;

    // Configuration register indexes
    typedef enum logic [INDEX_BITS-1:0] {
        REG_RECT_LEFT     = 3'd0,
        REG_RECT_TOP      = 3'd1,
        REG_RECT_WIDTH    = 3'd2,
        REG_RECT_HEIGHT   = 3'd3,
        REG_CORNER_STYLE  = 3'd4,
        REG_SCREEN_WIDTH  = 3'd5,
        REG_SCREEN_HEIGHT = 3'd6
    } cfg_reg_t;

    // Corner styles
    localparam logic [STYLE_BITS-1:0] STYLE_NONE  = 2'd0;
    localparam logic [STYLE_BITS-1:0] STYLE_WHITE = 2'd1;

    // Corner actions
    localparam logic [ACT_BITS-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_WHITE = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_BLACK = 2'd2;

    // Per-pixel facts that ride along the root chain
    typedef struct packed {
        logic [PIX_BITS-1:0] dx;
        logic                in_rect;
        logic                corner;
        logic                on_screen;
        logic                lattice;
    } pix_side_t;

    // One link of the square root chain
    typedef struct packed {
        logic [SQ_BITS-1:0] rem;
        logic [SQ_BITS-1:0] root;
        pix_side_t          side;
    } sqrt_stage_t;

endpackage

FILE: rtl/rrcm_sqrt_cell.sv
module rrcm_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  in_valid,
    input  rrcm_pkg::sqrt_stage_t in_stage,
    output logic                  out_valid,
    output rrcm_pkg::sqrt_stage_t out_stage
);
    import rrcm_pkg::*;

    // Bit pair handled by this cell
    localparam logic [SQ_BITS-1:0] BIT_VAL = SQ_BITS'(1) << (SQ_BITS - 2 - 2 * STEP);

    logic [SQ_BITS-1:0] trial;
    logic               take;
    sqrt_stage_t        stage_next;
    logic               valid_reg;
    sqrt_stage_t        stage_reg;

    // One restoring step of the digit-by-digit root
    always_comb
    begin
        trial           = in_stage.root + BIT_VAL;
        take            = in_stage.rem >= trial;
        stage_next.side = in_stage.side;
        if (take)
        begin
            stage_next.rem  = in_stage.rem - trial;
            stage_next.root = (in_stage.root >> 1) + BIT_VAL;
        end
        else
        begin
            stage_next.rem  = in_stage.rem;
            stage_next.root = in_stage.root >> 1;
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

FILE: rtl/rounded_rect_corner_mask.sv
// Stages from accept to result valid: stage A loads at the accept edge, then
// stages B and C, 9 root cells, and the output register.
// Throughput: one pixel per clock unless stalled; all stages advance together.
// Latency is set mostly by the 9-cell square root chain, one bit pair per cell.
// A held result stalls the whole pipeline in place; nothing is dropped.
// Reset clears all valid bits and loads register defaults (screen 4096x4096).
module rounded_rect_corner_mask #(
    parameter int COORD_BITS = 13
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rrcm_pkg::INDEX_BITS-1:0]      cfg_index,
    input  logic [(COORD_BITS > rrcm_pkg::SCREEN_BITS ?
                   COORD_BITS : rrcm_pkg::SCREEN_BITS)-1:0] cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rrcm_pkg::PIX_BITS-1:0]        pixel_x,
    input  logic [rrcm_pkg::PIX_BITS-1:0]        pixel_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 inside_shape,
    output logic [rrcm_pkg::ACT_BITS-1:0]        corner_action
);
    import rrcm_pkg::*;

    localparam int WIDE = (COORD_BITS > SCREEN_BITS ? COORD_BITS : SCREEN_BITS) + 2;
    localparam logic signed [WIDE-1:0] ONE_W = WIDE'(1);

    // Configuration registers
    logic signed [COORD_BITS-1:0]  rect_left_reg;
    logic signed [COORD_BITS-1:0]  rect_top_reg;
    logic [SIZE_BITS-1:0]          rect_width_reg;
    logic [SIZE_BITS-1:0]          rect_height_reg;
    logic [STYLE_BITS-1:0]         corner_style_reg;
    logic [SCREEN_BITS-1:0]        screen_width_reg;
    logic [SCREEN_BITS-1:0]        screen_height_reg;

    // Radius derived from the rectangle size
    logic [SIZE_BITS-1:0]                    min_side;
    logic [SIZE_BITS+DIV10_MUL_BITS-1:0]     div_prod;
    logic [ROOT_BITS-1:0]                    tenth;
    logic [ROOT_BITS-1:0]                    radius_next;
    logic                                    rounded_next;
    logic [SQ_BITS-1:0]                      radius_sq_next;
    logic [ROOT_BITS-1:0]                    radius_reg;
    logic [SQ_BITS-1:0]                      radius_sq_reg;
    logic                                    rounded_reg;

    // Pipeline control
    logic advance;

    // Stage A: offsets from the rectangle origin
    logic signed [WIDE-1:0] px_w;
    logic signed [WIDE-1:0] py_w;
    logic signed [WIDE-1:0] left_w;
    logic signed [WIDE-1:0] top_w;
    logic                   a_valid_reg;
    logic signed [WIDE-1:0] a_dx_reg;
    logic signed [WIDE-1:0] a_dy_reg;
    logic                   a_on_screen_reg;
    logic                   a_lattice_reg;

    // Stage B: rectangle test and corner row offset
    logic signed [WIDE-1:0] w_w;
    logic signed [WIDE-1:0] h_w;
    logic signed [WIDE-1:0] r_w;
    logic signed [WIDE-1:0] ry_w;
    logic                   in_rect_b;
    logic                   middle_b;
    pix_side_t              side_b;
    logic                   b_valid_reg;
    pix_side_t              b_side_reg;
    logic [ROOT_BITS-1:0]   b_ry_reg;

    // Stage C: radicand r*r - ry*ry
    logic [SQ_BITS-1:0]     ry_sq;
    sqrt_stage_t            c_stage_next;
    logic                   c_valid_reg;
    sqrt_stage_t            c_stage_reg;

    // Root chain
    logic                   chain_valid [0:SQRT_STEPS];
    sqrt_stage_t            chain_stage [0:SQRT_STEPS];

    // Stage D: span test and action
    sqrt_stage_t            last;
    logic [ROOT_BITS-1:0]   span;
    logic [SCREEN_BITS-1:0] dx_e;
    logic [SCREEN_BITS-1:0] span_lo;
    logic [SCREEN_BITS-1:0] span_hi;
    logic                   in_span;
    logic                   inside_next;
    logic [ACT_BITS-1:0]    action_next;
    logic                   out_valid_reg;
    logic                   inside_reg;
    logic [ACT_BITS-1:0]    action_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg     <= '0;
            rect_top_reg      <= '0;
            rect_width_reg    <= '0;
            rect_height_reg   <= '0;
            corner_style_reg  <= STYLE_NONE;
            screen_width_reg  <= SCREEN_RESET;
            screen_height_reg <= SCREEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RECT_LEFT:     rect_left_reg     <= cfg_data[COORD_BITS-1:0];
                REG_RECT_TOP:      rect_top_reg      <= cfg_data[COORD_BITS-1:0];
                REG_RECT_WIDTH:    rect_width_reg    <= cfg_data[SIZE_BITS-1:0];
                REG_RECT_HEIGHT:   rect_height_reg   <= cfg_data[SIZE_BITS-1:0];
                REG_CORNER_STYLE:  corner_style_reg  <= cfg_data[STYLE_BITS-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SCREEN_BITS-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SCREEN_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Radius: 1 for small sides, else side / 10 but at least 2
    always_comb
    begin
        min_side = (rect_width_reg < rect_height_reg) ? rect_width_reg : rect_height_reg;
        div_prod = {{DIV10_MUL_BITS{1'b0}}, min_side} *
                   {{SIZE_BITS{1'b0}}, DIV10_MUL};
        tenth    = div_prod[DIV10_SHIFT +: ROOT_BITS];
        if (min_side < MIN_SCALED_SIDE)
        begin
            radius_next = SMALL_RADIUS;
        end
        else if (tenth < MIN_RADIUS)
        begin
            radius_next = MIN_RADIUS;
        end
        else
        begin
            radius_next = tenth;
        end
        rounded_next   = (rect_width_reg >= MIN_ROUND_SIDE) &&
                         (rect_height_reg >= MIN_ROUND_SIDE);
        radius_sq_next = SQ_BITS'({{ROOT_BITS{1'b0}}, radius_reg} *
                                  {{ROOT_BITS{1'b0}}, radius_reg});
    end

    // Radius, then its square, settle before any following pixel needs them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= SMALL_RADIUS;
            radius_sq_reg <= SQ_BITS'(1);
            rounded_reg   <= 1'b0;
        end
        else
        begin
            radius_reg    <= radius_next;
            radius_sq_reg <= radius_sq_next;
            rounded_reg   <= rounded_next;
        end
    end

    // Whole pipeline moves unless a result is held at the output
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // Stage A
    always_comb
    begin
        px_w   = $signed({{(WIDE-PIX_BITS){1'b0}}, pixel_x});
        py_w   = $signed({{(WIDE-PIX_BITS){1'b0}}, pixel_y});
        left_w = $signed({{(WIDE-COORD_BITS){rect_left_reg[COORD_BITS-1]}}, rect_left_reg});
        top_w  = $signed({{(WIDE-COORD_BITS){rect_top_reg[COORD_BITS-1]}}, rect_top_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_dx_reg        <= px_w - left_w;
            a_dy_reg        <= py_w - top_w;
            a_on_screen_reg <= ({1'b0, pixel_x} < screen_width_reg) &&
                               ({1'b0, pixel_y} < screen_height_reg);
            a_lattice_reg   <= !pixel_x[0] && !pixel_y[0];
        end
    end

    // Stage B
    always_comb
    begin
        w_w       = $signed({{(WIDE-SIZE_BITS){1'b0}}, rect_width_reg});
        h_w       = $signed({{(WIDE-SIZE_BITS){1'b0}}, rect_height_reg});
        r_w       = $signed({{(WIDE-ROOT_BITS){1'b0}}, radius_reg});
        in_rect_b = (a_dx_reg >= 0) && (a_dx_reg < w_w) &&
                    (a_dy_reg >= 0) && (a_dy_reg < h_w);
        middle_b  = (a_dy_reg >= r_w) && (a_dy_reg < h_w - r_w);
        // distance from the corner center row, 1..r inside a corner band
        if (a_dy_reg < r_w)
        begin
            ry_w = r_w - a_dy_reg;
        end
        else
        begin
            ry_w = r_w - h_w + a_dy_reg + ONE_W;
        end
        side_b.dx        = a_dx_reg[PIX_BITS-1:0];
        side_b.in_rect   = in_rect_b;
        side_b.corner    = in_rect_b && rounded_reg && !middle_b;
        side_b.on_screen = a_on_screen_reg;
        side_b.lattice   = a_lattice_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_side_reg <= side_b;
            b_ry_reg   <= ry_w[ROOT_BITS-1:0];
        end
    end

    // Stage C
    always_comb
    begin
        ry_sq             = SQ_BITS'({{ROOT_BITS{1'b0}}, b_ry_reg} *
                                     {{ROOT_BITS{1'b0}}, b_ry_reg});
        c_stage_next.rem  = radius_sq_reg - ry_sq;
        c_stage_next.root = '0;
        c_stage_next.side = b_side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_stage_reg <= c_stage_next;
        end
    end

    // Square root chain, one bit pair per cell
    assign chain_valid[0] = c_valid_reg;
    assign chain_stage[0] = c_stage_reg;

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_cell
        rrcm_sqrt_cell #(
            .STEP(i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .in_valid (chain_valid[i]),
            .in_stage (chain_stage[i]),
            .out_valid(chain_valid[i+1]),
            .out_stage(chain_stage[i+1])
        );
    end

    // Stage D: span test against [r - span, W - r + span)
    always_comb
    begin
        last    = chain_stage[SQRT_STEPS];
        span    = last.root[ROOT_BITS-1:0];
        dx_e    = {1'b0, last.side.dx};
        span_lo = {{(SCREEN_BITS-ROOT_BITS){1'b0}}, radius_reg} -
                  {{(SCREEN_BITS-ROOT_BITS){1'b0}}, span};
        span_hi = {1'b0, rect_width_reg} +
                  {{(SCREEN_BITS-ROOT_BITS){1'b0}}, span} -
                  {{(SCREEN_BITS-ROOT_BITS){1'b0}}, radius_reg};
        in_span = (dx_e >= span_lo) && (dx_e < span_hi);

        inside_next = last.side.in_rect && (!last.side.corner || in_span);

        action_next = ACT_NONE;
        if (last.side.corner && !in_span && last.side.on_screen &&
            (corner_style_reg != STYLE_NONE))
        begin
            if (corner_style_reg == STYLE_WHITE)
            begin
                action_next = ACT_WHITE;
            end
            else if (last.side.lattice)
            begin
                action_next = ACT_BLACK;
            end
            else
            begin
                action_next = ACT_WHITE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_valid[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            inside_reg <= inside_next;
            action_reg <= action_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign inside_shape  = inside_reg;
    assign corner_action = action_reg;

    // A pixel inside the fill never gets a touch-up
    a_inside_no_action: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(inside_reg && (action_reg != ACT_NONE))
    ) else $error("corner action on a pixel inside the shape");

    // Style none suppresses every action
    a_style_none: assert property (
        @(posedge clk) disable iff (!rst_n)
        (chain_valid[SQRT_STEPS] && (corner_style_reg == STYLE_NONE)) |->
            (action_next == ACT_NONE)
    ) else $error("corner action with style none");

    // Requests are only held off while a result waits at the output
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg
    ) else $error("input stalled with empty output register");

endmodule

FILE: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrcm_pkg::*;

    localparam int CFG_BITS      = SCREEN_BITS;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_PIXELS  = 70;
    localparam int HOLD_CYCLES   = 300;
    // Output register plus root chain and front stages, with margin
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [STYLE_BITS-1:0] STYLE_DITHER = 2'd2;
    // Unused style code, treated as dither
    localparam logic [STYLE_BITS-1:0] STYLE_SPARE  = 2'd3;
    // Index past the register list; writes there must be dropped
    localparam logic [INDEX_BITS-1:0] REG_SPARE    = 3'd7;

    typedef struct packed {
        logic [PIX_BITS-1:0] x;
        logic [PIX_BITS-1:0] y;
    } pixel_req_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] x;
        logic [PIX_BITS-1:0] y;
        logic                fill;
        logic [ACT_BITS-1:0] action;
    } pixel_verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]   cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [PIX_BITS-1:0]   pixel_x = '0;
    logic [PIX_BITS-1:0]   pixel_y = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  inside_shape;
    logic [ACT_BITS-1:0]   corner_action;

    // Shadow copy of the shape registers
    longint                shape_left;
    longint                shape_top;
    longint                shape_width;
    longint                shape_height;
    logic [STYLE_BITS-1:0] shape_style;
    longint                screen_w;
    longint                screen_h;

    pixel_req_t     px_pending[$];
    pixel_verdict_t verdict_q[$];
    int             requests_issued = 0;
    int             results_seen = 0;
    int             mismatches = 0;
    int             cycle_count = 0;
    int             send_idle_pct = 30;
    int             recv_idle_pct = 30;
    bit             hold_burst = 1'b0;
    int             hold_left = 0;
    bit             req_taken = 1'b0;

    rounded_rect_corner_mask dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .inside_shape  (inside_shape),
        .corner_action (corner_action)
    );

    always #2 clk = ~clk;

    // Radius from the smaller side
    function automatic longint corner_radius_of(longint w, longint h);
        longint m;
        longint r;
        m = (w < h) ? w : h;
        if (m < 5)
            return 1;
        r = m / 10;
        if (r < 2)
            r = 2;
        if (2 * r > m)
            r = m / 2;
        return (r < 1) ? 1 : r;
    endfunction

    // Floor root of r^2 - ry^2, zero when not positive
    function automatic longint corner_span_of(longint r, longint ry);
        longint area;
        longint s;
        area = r * r - ry * ry;
        s = 0;
        if (area <= 0)
            return 0;
        while ((s + 1) * (s + 1) <= area)
            s++;
        return s;
    endfunction

    function automatic pixel_verdict_t classify_pixel(logic [PIX_BITS-1:0] px_in,
                                                      logic [PIX_BITS-1:0] py_in);
        pixel_verdict_t res;
        longint px;
        longint py;
        longint r;
        longint ry;
        longint span;
        bit     in_rect;
        bit     rounded;
        bit     in_fill;
        px = px_in;
        py = py_in;
        in_rect = px >= shape_left && px < shape_left + shape_width &&
                  py >= shape_top && py < shape_top + shape_height;
        rounded = shape_width >= 3 && shape_height >= 3;
        in_fill = 1'b0;
        if (in_rect && !rounded)
            in_fill = 1'b1;
        else if (in_rect) begin
            r = corner_radius_of(shape_width, shape_height);
            if (py >= shape_top + r && py < shape_top + shape_height - r)
                in_fill = 1'b1;
            else begin
                if (py - shape_top < r)
                    ry = r - (py - shape_top);
                else
                    ry = r - ((shape_top + shape_height - 1) - py);
                span = corner_span_of(r, ry);
                in_fill = px >= shape_left + r - span &&
                          px < shape_left + shape_width - r + span;
            end
        end
        res.x = px_in;
        res.y = py_in;
        res.fill = in_fill;
        res.action = ACT_NONE;
        if (in_rect && rounded && !in_fill && shape_style != STYLE_NONE &&
            px < screen_w && py < screen_h) begin
            if (shape_style == STYLE_WHITE)
                res.action = ACT_WHITE;
            else
                res.action = (!px_in[0] && !py_in[0]) ? ACT_BLACK : ACT_WHITE;
        end
        return res;
    endfunction

    // Register write, we stays high across back-to-back writes
    task automatic write_reg(input logic [INDEX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_RECT_LEFT:     shape_left = $signed(value);
            REG_RECT_TOP:      shape_top = $signed(value);
            REG_RECT_WIDTH:    shape_width = value[SIZE_BITS-1:0];
            REG_RECT_HEIGHT:   shape_height = value[SIZE_BITS-1:0];
            REG_CORNER_STYLE:  shape_style = value[STYLE_BITS-1:0];
            REG_SCREEN_WIDTH:  screen_w = value;
            REG_SCREEN_HEIGHT: screen_h = value;
            default: ;
        endcase
    endtask

    task automatic program_shape(input logic [CFG_BITS-1:0] left,
                                 input logic [CFG_BITS-1:0] top,
                                 input logic [CFG_BITS-1:0] w,
                                 input logic [CFG_BITS-1:0] h,
                                 input logic [CFG_BITS-1:0] style,
                                 input logic [CFG_BITS-1:0] sw,
                                 input logic [CFG_BITS-1:0] sh);
        write_reg(REG_RECT_LEFT, left);
        write_reg(REG_RECT_TOP, top);
        write_reg(REG_RECT_WIDTH, w);
        write_reg(REG_RECT_HEIGHT, h);
        write_reg(REG_CORNER_STYLE, style);
        write_reg(REG_SCREEN_WIDTH, sw);
        write_reg(REG_SCREEN_HEIGHT, sh);
        write_reg(REG_SPARE, CFG_BITS'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_pixel(input int x, input int y);
        pixel_req_t req;
        req.x = x[PIX_BITS-1:0];
        req.y = y[PIX_BITS-1:0];
        px_pending.push_back(req);
        requests_issued++;
    endtask

    // Block is idle once every issued request has produced its result
    task automatic wait_drained();
        while (results_seen < requests_issued)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [CFG_BITS-1:0] pick_origin();
        case ($urandom_range(0, 5))
            0:       return 13'h1000;
            1:       return 13'h0fff;
            2:       return '0;
            3:       return CFG_BITS'($urandom);
            default: return CFG_BITS'($urandom_range(0, 4000));
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return CFG_BITS'($urandom_range(0, 6));
            1:       return 13'd4095;
            2:       return CFG_BITS'($urandom);
            3, 4:    return CFG_BITS'($urandom_range(3, 4095));
            default: return CFG_BITS'($urandom_range(3, 64));
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_style();
        case ($urandom_range(0, 5))
            0:       return CFG_BITS'(STYLE_NONE);
            1:       return CFG_BITS'(STYLE_WHITE);
            2:       return CFG_BITS'(STYLE_SPARE);
            3:       return CFG_BITS'($urandom);
            default: return CFG_BITS'(STYLE_DITHER);
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_screen();
        case ($urandom_range(0, 7))
            0:       return 13'd1;
            1:       return '0;
            2:       return 13'h1fff;
            3:       return CFG_BITS'($urandom);
            4:       return CFG_BITS'($urandom_range(1, 4096));
            default: return SCREEN_RESET;
        endcase
    endfunction

    // Mostly corner neighborhoods, some anywhere in the box, some anywhere at all
    function automatic pixel_req_t pick_pixel();
        pixel_req_t req;
        longint     r;
        longint     x;
        longint     y;
        int         sel;
        r = corner_radius_of(shape_width, shape_height);
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            if ($urandom_range(0, 1))
                x = shape_left - 2 + $urandom_range(0, int'(r) + 4);
            else
                x = shape_left + shape_width - r - 2 + $urandom_range(0, int'(r) + 4);
            if ($urandom_range(0, 1))
                y = shape_top - 2 + $urandom_range(0, int'(r) + 4);
            else
                y = shape_top + shape_height - r - 2 + $urandom_range(0, int'(r) + 4);
        end else if (sel < 8) begin
            x = shape_left + $urandom_range(0, (shape_width > 0) ? int'(shape_width) - 1 : 0);
            y = shape_top + $urandom_range(0, (shape_height > 0) ? int'(shape_height) - 1 : 0);
        end else begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
        end
        if (x < 0 || x > 4095)
            x = $urandom_range(0, 4095);
        if (y < 0 || y > 4095)
            y = $urandom_range(0, 4095);
        req.x = x[PIX_BITS-1:0];
        req.y = y[PIX_BITS-1:0];
        return req;
    endfunction

    // Request driver
    always @(negedge clk) begin : drive_requests
        pixel_req_t next_req;
        if (rst_n) begin
            if (!in_valid || req_taken) begin
                if (px_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = px_pending.pop_front();
                    in_valid <= 1'b1;
                    pixel_x <= next_req.x;
                    pixel_y <= next_req.y;
                end else
                    in_valid <= 1'b0;
            end
            req_taken = 1'b0;
        end
    end

    // Predict on accept
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            verdict_q.push_back(classify_pixel(pixel_x, pixel_y));
            req_taken = 1'b1;
        end
    end

    // Result receiver: random stalls plus one long hold-off
    always @(negedge clk) begin
        if (hold_burst) begin
            hold_left = HOLD_CYCLES;
            hold_burst = 1'b0;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Result checker
    always @(posedge clk) begin : check_results
        pixel_verdict_t want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result inside_shape=%0b corner_action=%0d",
                         $time, inside_shape, corner_action);
                mismatches++;
            end else begin
                want = verdict_q.pop_front();
                if (inside_shape !== want.fill) begin
                    $display("%0t: pixel (%0d,%0d) inside_shape expected %0b got %0b",
                             $time, want.x, want.y, want.fill, inside_shape);
                    mismatches++;
                end
                if (corner_action !== want.action) begin
                    $display("%0t: pixel (%0d,%0d) corner_action expected %0d got %0d",
                             $time, want.x, want.y, want.action, corner_action);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        pixel_req_t req;
        shape_left = 0;
        shape_top = 0;
        shape_width = 0;
        shape_height = 0;
        shape_style = STYLE_NONE;
        screen_w = SCREEN_RESET;
        screen_h = SCREEN_RESET;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Reset defaults: empty rectangle, nothing inside
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        wait_drained();

        // Radius 3 box, dither: corner lattice points, span edges, mid rows
        program_shape(13'd10, 13'd20, 13'd40, 13'd30, CFG_BITS'(STYLE_DITHER),
                      SCREEN_RESET, SCREEN_RESET);
        queue_pixel(10, 20);
        queue_pixel(11, 20);
        queue_pixel(13, 20);
        queue_pixel(12, 21);
        queue_pixel(10, 22);
        queue_pixel(10, 23);
        queue_pixel(49, 49);
        queue_pixel(50, 50);
        queue_pixel(9, 20);
        wait_drained();

        // Too narrow to round: whole rectangle filled, no action
        program_shape(13'd100, 13'd100, 13'd2, 13'd50, CFG_BITS'(STYLE_WHITE),
                      SCREEN_RESET, SCREEN_RESET);
        queue_pixel(100, 100);
        queue_pixel(101, 149);
        queue_pixel(102, 100);
        wait_drained();

        // Narrow screen clips the corner action
        program_shape(13'd0, 13'd0, 13'd20, 13'd20, CFG_BITS'(STYLE_WHITE),
                      13'd5, SCREEN_RESET);
        queue_pixel(0, 0);
        queue_pixel(19, 0);
        queue_pixel(0, 19);
        wait_drained();

        // Unused style acts as dither, oversized screen
        program_shape(13'd0, 13'd0, 13'd8, 13'd8, CFG_BITS'(STYLE_SPARE),
                      13'h1fff, SCREEN_RESET);
        queue_pixel(0, 0);
        queue_pixel(7, 7);
        wait_drained();

        // Random shapes, each phase drained before the next setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0)
                program_shape(13'd0, 13'd0, 13'd4095, 13'd4095, CFG_BITS'(STYLE_DITHER),
                              SCREEN_RESET, SCREEN_RESET);
            else if (phase == 1)
                program_shape(13'h0fff, 13'h0fff, 13'd4095, 13'd4095,
                              CFG_BITS'(STYLE_WHITE), SCREEN_RESET, SCREEN_RESET);
            else
                program_shape(pick_origin(), pick_origin(), pick_size(), pick_size(),
                              pick_style(), pick_screen(), pick_screen());
            send_idle_pct = (phase == 5) ? 0 : 30;
            recv_idle_pct = (phase == 5) ? 0 : 30;
            if (phase == 3)
                hold_burst = 1'b1;
            repeat (PHASE_PIXELS) begin
                req = pick_pixel();
                queue_pixel(req.x, req.y);
            end
            wait_drained();
        end

        if (verdict_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, verdict_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
